// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/hmf_pkg.sv =====
// Package of the HTTP message framer: widths, character codes, key text and result type.
package hmf_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int OUT_LEN_BITS = 32;
    localparam int KEY_LEN = 15;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // One result item as it travels from the parser to the output register.
    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    in_body;
        logic                    header_last;
        logic                    message_last;
        logic                    length_found;
        logic [OUT_LEN_BITS-1:0] body_length;
    } t_result;

    // Text of the key "Content-Length:", one character per index.
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/hmf_parser.sv =====
// Byte parser of the framer: header matchers, length accumulator and body counter.
module hmf_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output hmf_pkg::t_result o_result
);
    import hmf_pkg::*;

    localparam int PROD_BITS = LENGTH_BITS + 4;

    typedef enum logic { PH_HEADER, PH_BODY } t_phase;
    typedef enum logic [1:0] { VS_KEY, VS_SKIP, VS_DIGITS, VS_DONE } t_vstage;

    t_phase                 r_phase, n_phase;
    t_vstage                r_vstage, n_vstage;
    logic [1:0]             r_term, n_term;
    logic [3:0]             r_key, n_key;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;

    logic                   in_body, header_last, message_last, term_hit, is_digit;
    logic [PROD_BITS-1:0]   prod;
    logic [LENGTH_BITS+OUT_LEN_BITS-1:0] acc_ext;

    assign is_digit = (i_byte inside {[CHAR_ZERO:CHAR_NINE]});
    // acc * 10 + digit, wide enough that overflow shows in the top four bits.
    assign prod = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                + PROD_BITS'(i_byte[3:0] - CHAR_ZERO[3:0]);

    always_comb begin
        n_phase      = r_phase;
        n_vstage     = r_vstage;
        n_term       = r_term;
        n_key        = r_key;
        n_acc        = r_acc;
        n_rem        = r_rem;
        in_body      = 1'b0;
        header_last  = 1'b0;
        message_last = 1'b0;
        term_hit     = 1'b0;

        if (r_phase == PH_BODY) begin
            in_body = 1'b1;
            n_rem = r_rem - LENGTH_BITS'(r_rem != '0);
            message_last = (n_rem == '0);
        end else begin
            // Content-Length key and value.
            case (r_vstage)
                VS_KEY: begin
                    if (i_byte == key_char(r_key)) begin
                        if (r_key == 4'(KEY_LEN - 1)) begin
                            n_key    = 4'd0;
                            n_vstage = VS_SKIP;
                        end else begin
                            n_key = r_key + 4'd1;
                        end
                    end else begin
                        n_key = (i_byte == key_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                end
                VS_SKIP, VS_DIGITS: begin
                    if (i_byte == CHAR_SPACE && r_vstage == VS_SKIP) begin
                        n_vstage = VS_SKIP;
                    end else if (is_digit) begin
                        n_acc = (|prod[PROD_BITS-1:LENGTH_BITS]) ? '1
                                                                : prod[LENGTH_BITS-1:0];
                        n_vstage = VS_DIGITS;
                    end else begin
                        n_vstage = VS_DONE;
                    end
                end
                default: begin
                    n_vstage = r_vstage;
                end
            endcase

            // Blank-line terminator CR LF CR LF.
            if (i_byte == CHAR_CR) begin
                n_term = (r_term == 2'd2) ? 2'd3 : 2'd1;
            end else if (i_byte == CHAR_LF && r_term == 2'd1) begin
                n_term = 2'd2;
            end else if (i_byte == CHAR_LF && r_term == 2'd3) begin
                n_term   = 2'd0;
                term_hit = 1'b1;
            end else begin
                n_term = 2'd0;
            end

            if (term_hit) begin
                header_last = 1'b1;
                if (n_acc == '0) begin
                    message_last = 1'b1;
                end else begin
                    n_phase = PH_BODY;
                    n_rem   = n_acc;
                end
            end
        end
    end

    assign acc_ext = {{OUT_LEN_BITS{1'b0}}, n_acc};

    always_comb begin
        o_result.out_byte     = i_byte;
        o_result.in_body      = in_body;
        o_result.header_last  = header_last;
        o_result.message_last = message_last;
        o_result.length_found = (n_vstage != VS_KEY);
        o_result.body_length  = (|acc_ext[LENGTH_BITS+OUT_LEN_BITS-1:OUT_LEN_BITS])
                              ? '1 : acc_ext[OUT_LEN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_vstage <= VS_KEY;
            r_term   <= 2'd0;
            r_key    <= 4'd0;
            r_acc    <= '0;
            r_rem    <= '0;
        end else if (i_accept) begin
            if (message_last) begin
                r_phase  <= PH_HEADER;
                r_vstage <= VS_KEY;
                r_term   <= 2'd0;
                r_key    <= 4'd0;
                r_acc    <= '0;
                r_rem    <= '0;
            end else begin
                r_phase  <= n_phase;
                r_vstage <= n_vstage;
                r_term   <= n_term;
                r_key    <= n_key;
                r_acc    <= n_acc;
                r_rem    <= n_rem;
            end
        end
    end

endmodule

// ===== hw/rtl/hmf_out_reg.sv =====
// Result register of the framer with its valid flag.
module hmf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hmf_pkg::t_result i_result,
    input  logic             i_taken,
    output logic             o_valid,
    output hmf_pkg::t_result o_result
);
    import hmf_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/http_message_framer.sv =====
// Top level of the HTTP message framer: stream ports, parser and result register.
//
// The framer takes the bytes of one connection, one request per byte, and
// splits them into HTTP messages framed by Content-Length. Every accepted
// byte yields exactly one result, which appears on the master side in the
// cycle after acceptance; while the master side takes results, the
// sustained rate is one byte per clock. That figure is set by the single
// pass of matcher and counter logic from the parser state into the result
// register. The slave side stays ready while the result register is empty
// or its contents are being taken in the same cycle. The header ends at the
// CR LF CR LF terminator; the first case-sensitive "Content-Length:" key in
// it is followed by optional spaces and decimal digits, which saturate at
// the counter maximum. A missing, empty or non-numeric value gives a length
// of zero, in which case the message ends on the final LF of the header.
// Otherwise that many body bytes follow and tlast marks the last of them;
// the byte after it starts a new message straight away.
`include "assert_macros.svh"

module http_message_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] out_byte, [39:8] body_length
    output logic        o_m_tlast,   // message_last
    output logic [2:0]  o_m_tuser    // [0] in_body, [1] header_last, [2] length_found
);
    import hmf_pkg::*;

    logic    accept;
    t_result parsed;
    t_result held;

    // The result register frees up when it is empty or drained this cycle.
    assign o_s_tready = !o_m_tvalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    hmf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .o_result (parsed)
    );

    hmf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (parsed),
        .i_taken  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_result (held)
    );

    assign o_m_tdata = {held.body_length, held.out_byte};
    assign o_m_tlast = held.message_last;
    assign o_m_tuser = {held.length_found, held.header_last, held.in_body};

    // A byte is never both body and header terminator.
    `ASSERT_IMPLIES(a_body_not_header, i_clk, i_rst_n, o_m_tvalid, !(o_m_tuser[0] && o_m_tuser[1]))
    // A header with zero length closes its message on the terminator itself.
    `ASSERT_IMPLIES(a_empty_body_ends, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1] && o_m_tdata[39:8] == 32'd0, o_m_tlast)
    // A body only exists after a length key was found.
    `ASSERT_IMPLIES(a_body_needs_key, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tuser[2])
    // Any byte that ends a message, in header or body, leaves the next one in the header.
    `ASSERT_NEXT(a_restart_header, i_clk, i_rst_n, accept && parsed.message_last, !u_parser.r_phase)

endmodule

// ===== verif/http_message_framer_test.sv =====
// Self-checking testbench for the HTTP message framer: directed and random byte streams.
`timescale 1ns / 1ps

module http_message_framer_test;
    import hmf_pkg::*;

    // Share of cycles, in percent, in which each side sits idle.
    localparam int unsigned IDLE_PCT = 28;
    // Both sides stay busy while this range of requests is being accepted.
    localparam int unsigned QUIET_FROM = 450;
    localparam int unsigned QUIET_TO = 600;
    // The receiver refuses results for a long stretch once this many have arrived.
    localparam int unsigned HOLD_AT = 300;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned RANDOM_BYTES = 480;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned REPORT_LIMIT = 10;

    localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "Content-Length:";
    localparam logic [63:0] LEN_CEILING = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam logic [63:0] OUT_CEILING = 64'hFFFF_FFFF;

    // Where the value after the key has got to within the current header.
    typedef enum logic [1:0] {
        VAL_NO_KEY,
        VAL_SPACES,
        VAL_DIGITS,
        VAL_DONE
    } t_value_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic [2:0]  o_m_tuser;

    http_message_framer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] data_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),  // [7:0] out_byte, [39:8] body_length
        .o_m_tlast  (o_m_tlast),  // message_last
        .o_m_tuser  (o_m_tuser)   // [0] in_body, [1] header_last, [2] length_found
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bytes waiting to be offered, and the framing expected for bytes already taken.
    logic [7:0]  pending_bytes[$];
    t_result     expected_frames[$];

    int unsigned bytes_accepted = 0;
    int unsigned results_taken = 0;
    int unsigned fail_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic        no_idle;

    string       token_chars = "abcdefghijklmnopqrstuvwxyz0123456789 -:/.";

    // Private copy of the framer state, advanced once per accepted request.
    bit           body_phase = 1'b0;
    int unsigned  crlf_seen = 0;
    int unsigned  key_seen = 0;
    t_value_state val_state = VAL_NO_KEY;
    logic [63:0]  parsed_len = 64'd0;
    logic [63:0]  body_left = 64'd0;

    t_result seen_frame;
    t_result due_frame;

    assign no_idle = (bytes_accepted >= QUIET_FROM) && (bytes_accepted < QUIET_TO);

    function automatic logic [7:0] key_at(input int unsigned idx);
        return KEY_TEXT[8*(KEY_LEN-1-idx) +: 8];
    endfunction

    // Works out how the framer labels one byte and moves the private state on.
    function automatic t_result frame_byte(input logic [7:0] b);
        t_result     r;
        logic [63:0] digit;
        bit          ends_header;
        r = '0;
        ends_header = 1'b0;
        if (body_phase) begin
            r.in_body = 1'b1;
            if (body_left != 0) begin
                body_left = body_left - 64'd1;
            end
            if (body_left == 0) begin
                r.message_last = 1'b1;
            end
        end else begin
            // Key search and value parsing run alongside the terminator search.
            case (val_state)
                VAL_NO_KEY: begin
                    if (key_seen < KEY_LEN && b == key_at(key_seen)) begin
                        key_seen = key_seen + 1;
                        if (key_seen == KEY_LEN) begin
                            key_seen = 0;
                            val_state = VAL_SPACES;
                        end
                    end else begin
                        // A mismatching 'C' may itself open a fresh attempt.
                        key_seen = (b == key_at(0)) ? 1 : 0;
                    end
                end
                VAL_SPACES, VAL_DIGITS: begin
                    if (b == CHAR_SPACE && val_state == VAL_SPACES) begin
                        val_state = VAL_SPACES;
                    end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        digit = {56'd0, b - CHAR_ZERO};
                        if (parsed_len > (LEN_CEILING - digit) / 64'd10) begin
                            parsed_len = LEN_CEILING;
                        end else begin
                            parsed_len = parsed_len * 64'd10 + digit;
                        end
                        val_state = VAL_DIGITS;
                    end else begin
                        val_state = VAL_DONE;
                    end
                end
                default: begin
                    val_state = VAL_DONE;
                end
            endcase

            if (b == CHAR_CR) begin
                crlf_seen = (crlf_seen == 2) ? 3 : 1;
            end else if (b == CHAR_LF && crlf_seen == 1) begin
                crlf_seen = 2;
            end else if (b == CHAR_LF && crlf_seen == 3) begin
                crlf_seen = 0;
                ends_header = 1'b1;
            end else begin
                crlf_seen = 0;
            end

            if (ends_header) begin
                r.header_last = 1'b1;
                if (parsed_len == 0) begin
                    r.message_last = 1'b1;
                end else begin
                    body_phase = 1'b1;
                    body_left = parsed_len;
                end
            end
        end

        r.out_byte = b;
        r.length_found = (val_state != VAL_NO_KEY);
        r.body_length = (parsed_len > OUT_CEILING) ? OUT_CEILING[31:0] : parsed_len[31:0];

        // The byte after a finished message starts the next one from scratch.
        if (r.message_last) begin
            body_phase = 1'b0;
            crlf_seen = 0;
            key_seen = 0;
            val_state = VAL_NO_KEY;
            parsed_len = 64'd0;
            body_left = 64'd0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        end
    endtask

    // Appends one byte to the stream waiting to be offered.
    task automatic add_byte(input logic [7:0] b);
        pending_bytes = {pending_bytes, b};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    // Header filler drawn from characters that can never start the key.
    task automatic push_token(input int unsigned n);
        repeat (n) begin
            add_byte(token_chars[$urandom_range(token_chars.len() - 1)]);
        end
    endtask

    task automatic push_random_bytes(input int unsigned n);
        repeat (n) begin
            add_byte(8'($urandom_range(255)));
        end
    endtask

    // A well-formed message with random content; the body is as long as the
    // first key's value says, so the stream stays in step with the framing.
    task automatic queue_random_message();
        int unsigned lines;
        int unsigned form;
        int unsigned len;
        bit          keyed;
        len = 0;
        keyed = ($urandom_range(99) < 75);
        push_text("GET /");
        push_token($urandom_range(1, 6));
        push_text(" HTTP/1.1\r\n");
        lines = $urandom_range(3);
        repeat (lines) begin
            push_token($urandom_range(1, 10));
            push_text(": ");
            push_token($urandom_range(8));
            push_text("\r\n");
        end
        if ($urandom_range(99) < 15) begin
            if (keyed) begin
                push_text("Content-Lengt: 9\r\n");
            end else begin
                push_text("content-length: 9\r\n");
            end
        end
        if (keyed) begin
            form = $urandom_range(9);
            push_text("Content-Length:");
            repeat ($urandom_range(3)) begin
                add_byte(CHAR_SPACE);
            end
            case (form)
                0: begin
                    len = 0;
                end
                1: begin
                    len = 0;
                    push_text("x");
                    push_token($urandom_range(4));
                end
                2: begin
                    len = $urandom_range(1, 24);
                    push_text($sformatf("%0d;", len));
                    push_token($urandom_range(4));
                end
                3: begin
                    len = $urandom_range(24);
                    push_text($sformatf("00%0d", len));
                end
                4: begin
                    len = 0;
                    push_text("0");
                end
                default: begin
                    len = $urandom_range(24);
                    push_text($sformatf("%0d", len));
                end
            endcase
            push_text("\r\n");
            // A second key must be ignored by the framer.
            if ($urandom_range(99) < 30) begin
                push_text($sformatf("Content-Length: %0d\r\n", $urandom_range(99)));
            end
        end
        push_text("\r\n");
        push_random_bytes(len);
    endtask

    // Noise and broken sequences between messages.
    task automatic queue_noise();
        case ($urandom_range(3))
            0: push_random_bytes($urandom_range(1, 12));
            1: push_text("\r\n\r");
            2: push_text("\r\n\nx\n\r\n");
            default: begin
                push_text("Content-Le");
                push_token($urandom_range(1, 4));
            end
        endcase
    endtask

    // Lets the stream run dry and every expected result come back.
    task automatic wait_drained();
        int unsigned guard;
        guard = 0;
        while ((pending_bytes.size() != 0 || s_tvalid || expected_frames.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard = guard + 1;
        end
    endtask

    // Sender: offers the next pending byte unless it idles this cycle. A byte
    // on offer is held until the request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_tready) begin
            if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_bytes[0];
                pending_bytes.delete(0);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so that the
    // framer's result register fills and its input side stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && results_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts each accepted request and checks each result taken
    // against the oldest prediction still outstanding.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && o_s_tready) begin
                expected_frames = {expected_frames, frame_byte(s_tdata)};
                bytes_accepted <= bytes_accepted + 1;
            end
            if (o_m_tvalid && m_tready) begin
                results_taken <= results_taken + 1;
                seen_frame.out_byte = o_m_tdata[7:0];
                seen_frame.body_length = o_m_tdata[39:8];
                seen_frame.in_body = o_m_tuser[0];
                seen_frame.header_last = o_m_tuser[1];
                seen_frame.length_found = o_m_tuser[2];
                seen_frame.message_last = o_m_tlast;
                if (expected_frames.size() == 0) begin
                    flag_mismatch("unexpected result, out_byte", 32'd0,
                                  {24'd0, seen_frame.out_byte});
                end else begin
                    due_frame = expected_frames[0];
                    expected_frames.delete(0);
                    if (seen_frame.out_byte != due_frame.out_byte)
                        flag_mismatch("out_byte", 32'(due_frame.out_byte),
                                      32'(seen_frame.out_byte));
                    if (seen_frame.in_body != due_frame.in_body)
                        flag_mismatch("in_body", 32'(due_frame.in_body),
                                      32'(seen_frame.in_body));
                    if (seen_frame.header_last != due_frame.header_last)
                        flag_mismatch("header_last", 32'(due_frame.header_last),
                                      32'(seen_frame.header_last));
                    if (seen_frame.message_last != due_frame.message_last)
                        flag_mismatch("message_last", 32'(due_frame.message_last),
                                      32'(seen_frame.message_last));
                    if (seen_frame.length_found != due_frame.length_found)
                        flag_mismatch("length_found", 32'(due_frame.length_found),
                                      32'(seen_frame.length_found));
                    if (seen_frame.body_length != due_frame.body_length)
                        flag_mismatch("body_length", due_frame.body_length,
                                      seen_frame.body_length);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed messages: no key, a plain body, an empty value, a
        // non-numeric value, garbage after the digits, a second key that
        // must be ignored, a key found on a retry with a leading zero and a
        // body that looks like a terminator, a lower-case key, terminator
        // near misses, and the byte extremes in header and body.
        push_text("A\r\n\r\n");
        push_text("Content-Length: 3\r\n\r\nabc");
        push_text("Content-Length:\r\n\r\n");
        push_text("Content-Length:  x5\r\n\r\n");
        push_text("Content-Length: 2x9\r\n\r\nhi");
        push_text("Content-Length: 1\r\nContent-Length: 5\r\n\r\nZ");
        push_text("ContCContent-Length:04\r\n\r\n\r\n\r\n");
        push_text("content-length: 7\r\n\r\n");
        push_text("\r\r\n\n\r\n\r\n");
        add_byte(8'hFF);
        add_byte(8'h00);
        push_text("Content-Length: 2\r\n\r\n");
        add_byte(8'h00);
        add_byte(8'hFF);

        // The sender pauses here until every result of the directed part is in.
        wait_drained();

        while (pending_bytes.size() < RANDOM_BYTES) begin
            if ($urandom_range(99) < 85) begin
                queue_random_message();
            end else begin
                queue_noise();
            end
        end

        // A length far beyond the counter saturates; its body never ends, so
        // this message closes the run.
        push_text("Content-Length: 42949672951\r\n\r\n");
        push_random_bytes(6);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_frames.size() != 0) begin
            flag_mismatch("outstanding results", 32'd0, expected_frames.size());
        end
        if (fail_count == 0) begin
            $display("http_message_framer test passed");
        end else begin
            $display("http_message_framer test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("http_message_framer test failed");
        $finish;
    end

endmodule

// ===== http_message_framer.f =====
+incdir+hw/rtl
hw/rtl/hmf_pkg.sv
hw/rtl/hmf_parser.sv
hw/rtl/hmf_out_reg.sv
hw/rtl/http_message_framer.sv
verif/http_message_framer_test.sv
